// ===== src/lis_pkg.sv =====
// Shared constants for the longest increasing subsequence block.
// No dependencies; imported by lis_cell and the top level.
`timescale 1ns / 1ps

package lis_pkg;

    // Fixed field widths of the transfer ports.
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int RUN_W   = 7;

    // Longest run that is ever reported; later elements of a longer chain are cut.
    localparam int RESULT_LIMIT = 64;

    // Default capacity of the element row.
    localparam int MAX_ELEMENTS_DEF = 64;

endpackage

// ===== src/lis_cell.sv =====
// One cell of the element row: holds one stored element and relays the scan token.
// Depends on lis_pkg.
`timescale 1ns / 1ps

module lis_cell
    import lis_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int INDEX        = 0,
    localparam int CNT_W       = $clog2(MAX_ELEMENTS + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [CNT_W-1:0]           count,
    input  logic                       shift_en,
    input  logic signed [VALUE_W-1:0]  shift_val,
    input  logic [CNT_W-1:0]           shift_len,
    input  logic [CNT_W-1:0]           shift_pred,
    output logic signed [VALUE_W-1:0]  val,
    output logic [CNT_W-1:0]           len,
    output logic [CNT_W-1:0]           pred,
    input  logic                       tok_in_valid,
    input  logic signed [VALUE_W-1:0]  tok_in_val,
    input  logic [CNT_W-1:0]           tok_in_best,
    input  logic [CNT_W-1:0]           tok_in_pred,
    output logic                       tok_out_valid,
    output logic signed [VALUE_W-1:0]  tok_out_val,
    output logic [CNT_W-1:0]           tok_out_best,
    output logic [CNT_W-1:0]           tok_out_pred
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]          len_reg, len_next;
    logic [CNT_W-1:0]          pred_reg, pred_next;
    logic                      tok_valid_reg;
    logic signed [VALUE_W-1:0] tok_val_reg;
    logic [CNT_W-1:0]          tok_best_reg, tok_best_next;
    logic [CNT_W-1:0]          tok_pred_reg, tok_pred_next;
    logic [CNT_W-1:0]          len_plus;
    logic                      occupied;
    logic                      better;

    assign occupied = MY_INDEX < count;
    assign len_plus = len_reg + CNT_W'(1);
    // A strictly smaller earlier element extends the chain; ties go to the later element.
    assign better   = occupied && (val_reg < tok_in_val) && (len_plus >= tok_in_best);

    always_comb
    begin
        tok_best_next = better ? len_plus : tok_in_best;
        tok_pred_next = better ? MY_INDEX : tok_in_pred;
        val_next      = val_reg;
        len_next      = len_reg;
        pred_next     = pred_reg;
        if (shift_en)
        begin
            val_next  = shift_val;
            len_next  = shift_len;
            pred_next = shift_pred;
        end
        else if (tok_in_valid && (MY_INDEX == count))
        begin
            // The token has seen every earlier element, so its result lands here.
            val_next  = tok_in_val;
            len_next  = tok_in_best;
            pred_next = tok_in_pred;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        len_reg      <= len_next;
        pred_reg     <= pred_next;
        tok_val_reg  <= tok_in_val;
        tok_best_reg <= tok_best_next;
        tok_pred_reg <= tok_pred_next;
    end

    assign val           = val_reg;
    assign len           = len_reg;
    assign pred          = pred_reg;
    assign tok_out_valid = tok_valid_reg;
    assign tok_out_val   = tok_val_reg;
    assign tok_out_best  = tok_best_reg;
    assign tok_out_pred  = tok_pred_reg;

endmodule

// ===== src/longest_increasing_subsequence.sv =====
// Top level of the longest increasing subsequence block: control and the cell row.
// Depends on lis_pkg and lis_cell.
`timescale 1ns / 1ps

// Usage
// An element is transferred in at a rising edge where start is high and busy is
// low. Each element enters a row of MAX_ELEMENTS cells as a token that moves one
// cell per cycle; every occupied cell it passes may extend its best chain, and the
// cell at the current fill position stores the element. An element therefore keeps
// busy high until its token has passed the whole row. Elements that arrive once
// the row is full are dropped at once, but their is_last mark still counts.
// After the element marked is_last, the row shifts toward its far end one cell per
// cycle and the far cell is watched: when its index matches the traced position,
// one result is transferred out with strobe high for a single cycle, newest element
// first. end_of_run marks the final result. When the readout ends, the block is
// empty and idle again.
// The receiver cannot stall; results are simply presented and must be taken.
// Reset empties the sequence and clears all control state; the stored elements
// themselves are not cleared, since only filled cells are ever consulted.
module longest_increasing_subsequence
    import lis_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       is_last,
    output logic                       strobe,
    output logic [POS_W-1:0]           position,
    output logic signed [VALUE_W-1:0]  element,
    output logic [RUN_W-1:0]           run_length,
    output logic                       end_of_run
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] NO_PRED  = CNT_W'(MAX_ELEMENTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          max_len_reg, max_len_next;
    logic [IDX_W-1:0]          end_reg, end_next;
    logic                      last_reg, last_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          target_reg, target_next;
    logic [RUN_W-1:0]          emitted_reg, emitted_next;
    logic                      strobe_reg, strobe_next;
    logic [POS_W-1:0]          position_reg, position_next;
    logic signed [VALUE_W-1:0] element_reg, element_next;
    logic [RUN_W-1:0]          run_length_reg, run_length_next;
    logic                      end_of_run_reg, end_of_run_next;

    // Row wiring: entry i of each cell array is the output of cell i; the token
    // arrays carry one more entry, entry 0 being the injection point in front of cell 0.
    logic signed [VALUE_W-1:0] cell_val  [MAX_ELEMENTS];
    logic [CNT_W-1:0]          cell_len  [MAX_ELEMENTS];
    logic [CNT_W-1:0]          cell_pred [MAX_ELEMENTS];
    logic                      tok_valid [MAX_ELEMENTS+1];
    logic signed [VALUE_W-1:0] tok_val   [MAX_ELEMENTS+1];
    logic [CNT_W-1:0]          tok_best  [MAX_ELEMENTS+1];
    logic [CNT_W-1:0]          tok_pred  [MAX_ELEMENTS+1];
    logic                      shift_en;
    logic                      inject;
    logic                      hit;
    logic                      final_hit;

    // A new element starts with a chain of one and no predecessor.
    assign tok_valid[0] = inject;
    assign tok_val[0]   = value;
    assign tok_best[0]  = CNT_W'(1);
    assign tok_pred[0]  = NO_PRED;
    assign shift_en     = (state_reg == ST_EMIT);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++)
        begin : g_cell
            logic signed [VALUE_W-1:0] sh_val;
            logic [CNT_W-1:0]          sh_len;
            logic [CNT_W-1:0]          sh_pred;

            if (gi == 0)
            begin : g_head
                assign sh_val  = '0;
                assign sh_len  = '0;
                assign sh_pred = NO_PRED;
            end
            else
            begin : g_body
                assign sh_val  = cell_val[gi-1];
                assign sh_len  = cell_len[gi-1];
                assign sh_pred = cell_pred[gi-1];
            end

            lis_cell #(
                .MAX_ELEMENTS (MAX_ELEMENTS),
                .INDEX        (gi)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .count         (count_reg),
                .shift_en      (shift_en),
                .shift_val     (sh_val),
                .shift_len     (sh_len),
                .shift_pred    (sh_pred),
                .val           (cell_val[gi]),
                .len           (cell_len[gi]),
                .pred          (cell_pred[gi]),
                .tok_in_valid  (tok_valid[gi]),
                .tok_in_val    (tok_val[gi]),
                .tok_in_best   (tok_best[gi]),
                .tok_in_pred   (tok_pred[gi]),
                .tok_out_valid (tok_valid[gi+1]),
                .tok_out_val   (tok_val[gi+1]),
                .tok_out_best  (tok_best[gi+1]),
                .tok_out_pred  (tok_pred[gi+1])
            );
        end
    endgenerate

    // During readout the far cell holds entry idx_reg; it belongs to the run when
    // its index is the one the predecessor trace points at.
    assign hit       = (CNT_W'(idx_reg) == target_reg);
    assign final_hit = hit && ((cell_pred[MAX_ELEMENTS-1] == NO_PRED) ||
                               (emitted_reg == RUN_W'(RESULT_LIMIT - 1)));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        max_len_next    = max_len_reg;
        end_next        = end_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        target_next     = target_reg;
        emitted_next    = emitted_reg;
        strobe_next     = 1'b0;
        position_next   = position_reg;
        element_next    = element_reg;
        run_length_next = run_length_reg;
        end_of_run_next = end_of_run_reg;
        inject          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (count_reg < NO_PRED)
                    begin
                        inject     = 1'b1;
                        last_next  = is_last;
                        state_next = ST_SCAN;
                    end
                    else if (is_last)
                    begin
                        // Row is full: the element is dropped but the run is read out.
                        idx_next     = LAST_IDX;
                        target_next  = CNT_W'(end_reg);
                        emitted_next = '0;
                        state_next   = ST_EMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                if (tok_valid[MAX_ELEMENTS])
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (tok_best[MAX_ELEMENTS] >= max_len_reg)
                    begin
                        max_len_next = tok_best[MAX_ELEMENTS];
                        end_next     = count_reg[IDX_W-1:0];
                    end
                    if (last_reg)
                    begin
                        idx_next     = LAST_IDX;
                        target_next  = CNT_W'(end_next);
                        emitted_next = '0;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT:
            begin
                idx_next = idx_reg - IDX_W'(1);
                if (hit)
                begin
                    strobe_next     = 1'b1;
                    position_next   = POS_W'(idx_reg);
                    element_next    = cell_val[MAX_ELEMENTS-1];
                    run_length_next = RUN_W'(max_len_reg);
                    end_of_run_next = final_hit;
                    emitted_next    = emitted_reg + RUN_W'(1);
                    target_next     = cell_pred[MAX_ELEMENTS-1];
                end
                if (final_hit || (idx_reg == '0))
                begin
                    count_next   = '0;
                    max_len_next = '0;
                    end_next     = '0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            max_len_reg    <= '0;
            end_reg        <= '0;
            last_reg       <= 1'b0;
            idx_reg        <= '0;
            target_reg     <= '0;
            emitted_reg    <= '0;
            strobe_reg     <= 1'b0;
            position_reg   <= '0;
            element_reg    <= '0;
            run_length_reg <= '0;
            end_of_run_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            max_len_reg    <= max_len_next;
            end_reg        <= end_next;
            last_reg       <= last_next;
            idx_reg        <= idx_next;
            target_reg     <= target_next;
            emitted_reg    <= emitted_next;
            strobe_reg     <= strobe_next;
            position_reg   <= position_next;
            element_reg    <= element_next;
            run_length_reg <= run_length_next;
            end_of_run_reg <= end_of_run_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign position   = position_reg;
    assign element    = element_reg;
    assign run_length = run_length_reg;
    assign end_of_run = end_of_run_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the longest increasing subsequence block.
// Depends on lis_pkg and the longest_increasing_subsequence top level.
`timescale 1ns / 1ps

module tb_top;
    import lis_pkg::*;

    // The block is built at its default capacity so that the longest chain fills
    // every position and run_length reaches LIS_DEPTH.
    localparam int LIS_DEPTH      = MAX_ELEMENTS_DEF;
    localparam int NO_PREDECESSOR = LIS_DEPTH;

    // A correct block never goes this many cycles without taking an element or
    // presenting a result. The worst honest stretch is a sender gap plus one
    // element pass plus a readout gap, well under this bound.
    localparam int IDLE_LIMIT   = 2000;
    // Quiet time after the last expected result; any stray strobe in this window
    // is caught as a result with nothing waiting for it.
    localparam int DRAIN_CYCLES = 2 * LIS_DEPTH + 20;
    // Least number of elements sent in the random sequence phase.
    localparam int RANDOM_ITEMS = 110;

    typedef struct {
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] element;
        logic [RUN_W-1:0]          run_length;
        logic                      end_of_run;
    } lis_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
    logic                      strobe;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] element;
    logic [RUN_W-1:0]          run_length;
    logic                      end_of_run;

    // Our own copy of the element store: values, the chain length that ends at
    // each element, and the index of the predecessor on that chain.
    logic signed [VALUE_W-1:0] held_values [LIS_DEPTH];
    int                        chain_len   [LIS_DEPTH];
    int                        chain_prev  [LIS_DEPTH];
    int                        held_count;

    // Subsequence results still owed by the block, oldest first.
    lis_result_t pending_subsequence[$];
    lis_result_t oldest_expected;

    int  fail_count;
    int  idle_cycles;
    int  sent_items;
    // While set, the sender puts elements back to back with no gaps.
    bit  burst_mode;

    longest_increasing_subsequence #(
        .MAX_ELEMENTS (LIS_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .is_last    (is_last),
        .strobe     (strobe),
        .position   (position),
        .element    (element),
        .run_length (run_length),
        .end_of_run (end_of_run)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Fold one accepted element into the chain store. Each new element extends
    // the longest chain among the earlier, strictly smaller elements; on a tie in
    // length the latest such element becomes the predecessor. An element that
    // arrives with the store full is dropped, but its end mark still counts.
    // On the end mark the latest element with the longest chain is traced back
    // through its predecessors, and one result is owed per element on the way.
    function automatic void extend_chains(logic signed [VALUE_W-1:0] v, logic last);
        int          best;
        int          prev;
        int          best_len;
        int          tail;
        int          cur;
        int          emitted;
        lis_result_t r;

        if (held_count < LIS_DEPTH)
        begin
            best = 1;
            prev = NO_PREDECESSOR;
            for (int i = 0; i < held_count; i++)
            begin
                if (held_values[i] < v && chain_len[i] + 1 >= best)
                begin
                    best = chain_len[i] + 1;
                    prev = i;
                end
            end
            held_values[held_count] = v;
            chain_len[held_count]   = best;
            chain_prev[held_count]  = prev;
            held_count++;
        end
        if (!last)
            return;

        best_len = 0;
        tail     = 0;
        for (int i = 0; i < held_count; i++)
        begin
            if (chain_len[i] >= best_len)
            begin
                best_len = chain_len[i];
                tail     = i;
            end
        end

        // Walk from the chain's end back to its start, newest element first.
        // At most RESULT_LIMIT results are reported for one chain.
        cur     = tail;
        emitted = 0;
        while (cur < held_count && emitted < RESULT_LIMIT)
        begin
            r.position   = POS_W'(cur);
            r.element    = held_values[cur];
            r.run_length = RUN_W'(best_len);
            r.end_of_run = !(chain_prev[cur] < held_count) || emitted == RESULT_LIMIT - 1;
            pending_subsequence.push_back(r);
            emitted++;
            if (r.end_of_run)
                break;
            cur = chain_prev[cur];
        end
        held_count = 0;
    endfunction

    // Send one element. On entry we stand just after a rising edge (or at the
    // start of the run); inputs only move at falling edges. With no gap, start
    // simply stays high and the new payload replaces the old one, so start is
    // never lowered and raised in the same time step. The transfer happens at the
    // first rising edge that sees busy low, and the prediction is made right then.
    task automatic send_element(logic signed [VALUE_W-1:0] v, logic last);
        int gap;

        gap = burst_mode ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        is_last <= last;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        extend_chains(v, last);
        sent_items++;
    endtask

    // A lone element that is also the end: a one-long chain at position zero.
    task automatic test_single_element();
        send_element(32'sh7fff_ffff, 1'b1);
    endtask

    // Strictly increasing run through the signed extremes; the whole input is
    // the chain, and the comparison must treat the top bit as a sign.
    task automatic test_signed_extremes();
        send_element(32'sh8000_0000, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element(32'sd0, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(32'sh7fff_ffff, 1'b1);
    endtask

    // Equal and falling values never extend a chain, so every element has length
    // one and the latest element alone is reported.
    task automatic test_no_increase();
        send_element(32'sd7, 1'b0);
        send_element(32'sd7, 1'b0);
        send_element(-32'sd3, 1'b0);
        send_element(32'sh8000_0000, 1'b1);
    endtask

    // Several chains of the same length: the latest predecessor and the latest
    // chain end must win.
    task automatic test_tie_breaks();
        send_element(32'sd3, 1'b0);
        send_element(32'sd1, 1'b0);
        send_element(32'sd4, 1'b0);
        send_element(32'sd2, 1'b0);
        send_element(32'sd5, 1'b0);
        send_element(32'sd5, 1'b0);
        send_element(32'sd0, 1'b1);
    endtask

    // Fill the store to capacity and then send more elements that are dropped;
    // the dropped final element still carries the end mark. With a rising fill
    // the chain covers every position and run_length reaches its maximum.
    task automatic test_full_store(bit rising);
        longint level;

        level = -64'sd2147483648 + longint'($urandom_range(0, 1000));
        for (int i = 0; i < LIS_DEPTH; i++)
        begin
            if (rising)
            begin
                send_element(VALUE_W'(level), 1'b0);
                level += $urandom_range(1, 1 << 25);
            end
            else
                send_element($urandom, 1'b0);
        end
        send_element($urandom, 1'b0);
        send_element($urandom, 1'b1);
    endtask

    // Short sequences with random content. Narrow value ranges give plenty of
    // equal values and tied chains; full-range values exercise every value bit.
    // Now and then a whole sequence goes back to back with no sender gaps.
    task automatic test_random_runs();
        int first_item;
        int span;
        int narrow;

        first_item = sent_items;
        while (sent_items - first_item < RANDOM_ITEMS)
        begin
            span       = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24)
                                                     : $urandom_range(1, 10);
            narrow     = $urandom_range(0, 1);
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < span; i++)
            begin
                if (narrow != 0)
                    send_element(int'($urandom_range(0, 8)) - 4, i == span - 1);
                else
                    send_element($urandom, i == span - 1);
            end
        end
        burst_mode = 1'b0;
    endtask

    // Each strobed result is compared against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_subsequence.size() == 0)
            begin
                $error("unexpected result: position %0d element %0d", position, element);
                fail_count++;
            end
            else
            begin
                oldest_expected = pending_subsequence.pop_front();
                if (position !== oldest_expected.position)
                begin
                    $error("position: expected %0d, actual %0d",
                           oldest_expected.position, position);
                    fail_count++;
                end
                if (element !== oldest_expected.element)
                begin
                    $error("element: expected %0d, actual %0d",
                           oldest_expected.element, element);
                    fail_count++;
                end
                if (run_length !== oldest_expected.run_length)
                begin
                    $error("run_length: expected %0d, actual %0d",
                           oldest_expected.run_length, run_length);
                    fail_count++;
                end
                if (end_of_run !== oldest_expected.end_of_run)
                begin
                    $error("end_of_run: expected %0d, actual %0d",
                           oldest_expected.end_of_run, end_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with neither an input transfer nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("longest_increasing_subsequence regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        is_last     = 1'b0;
        held_count  = 0;
        fail_count  = 0;
        idle_cycles = 0;
        sent_items  = 0;
        burst_mode  = 1'b0;

        // Reset is held from time zero, then released at a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element();
        test_signed_extremes();
        test_no_increase();
        test_tie_breaks();
        test_full_store(1'b1);
        test_random_runs();
        test_full_store(1'b0);

        @(negedge clk);
        start   <= 1'b0;
        is_last <= 1'b0;

        // Wait for every owed result, then give the block time to show any extra.
        while (pending_subsequence.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("longest_increasing_subsequence regression: pass");
        else
            $display("longest_increasing_subsequence regression: fail");
        $finish;
    end

endmodule
